/* rtl/core/stpd_pkg.sv */
// shared types, constants and arithmetic helpers for the diagonal scaling block
`timescale 1ns / 1ps
package stpd_pkg;

    localparam int MAX_ROWS_DEF      = 1024;
    localparam int MAX_A_DEF         = 16384;
    localparam int MAX_FACTOR_DEF    = 16384;

    localparam int PTR_W   = 15;
    localparam int COL_W   = 10;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 11;
    localparam int ROW_W   = 10;
    localparam int STAT_W  = 2;
    localparam int FUNC_W  = 3;

    localparam logic signed [VAL_W-1:0] Q_ONE   = 32'sh0100_0000;
    localparam logic signed [VAL_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] S32_MIN = 32'sh8000_0000;
    localparam logic [31:0] RSQ_SAT_LIMIT = 32'd1024;

    typedef enum logic [FUNC_W-1:0] {
        F_A_PTR    = 3'd0,
        F_A_ENTRY  = 3'd1,
        F_F_PTR    = 3'd2,
        F_F_ENTRY  = 3'd3,
        F_COMPUTE  = 3'd4
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_ZERO  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_FSR, S_FS, S_FE, S_JCHK, S_JRD, S_AS, S_AE,
        S_MCHK, S_MCMP, S_MACC, S_OMUL, S_OACC, S_FIN, S_RSQ, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        RSQ_IDLE, RSQ_DIV, RSQ_SQRT
    } t_rsq_state;

    typedef struct packed {
        logic        start;
        logic [31:0] mag;
    } t_rsq_req;

    typedef struct packed {
        logic        done;
        logic [31:0] root;
    } t_rsq_rsp;

    function automatic logic signed [VAL_W-1:0] sat_add(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        logic [VAL_W:0] s;
        s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1]) begin
            return s[VAL_W] ? S32_MIN : S32_MAX;
        end
        return s[VAL_W-1:0];
    endfunction

    // round half up to q8.24 and saturate
    function automatic logic signed [VAL_W-1:0] q_round(input logic signed [63:0] p);
        logic signed [63:0] r;
        r = (p + 64'sd8388608) >>> 24;
        if (r > 64'(S32_MAX)) begin
            return S32_MAX;
        end else if (r < 64'(S32_MIN)) begin
            return S32_MIN;
        end
        return r[VAL_W-1:0];
    endfunction

endpackage

/* rtl/core/stpd_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
module stpd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/stpd_rsqrt.sv */
// iterative floor(2^36/sqrt(m)): bit-serial division of 2^72 then integer square root
`timescale 1ns / 1ps
module stpd_rsqrt (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stpd_pkg::t_rsq_req i_req,
    output stpd_pkg::t_rsq_rsp o_rsp
);
    import stpd_pkg::*;

    t_rsq_state   r_state;
    logic [31:0]  r_mag;
    logic [31:0]  r_rem;
    logic [62:0]  r_quo;
    logic [6:0]   r_cnt;
    logic [63:0]  r_x;
    logic [63:0]  r_res;
    logic [63:0]  r_bit;
    logic         r_done;
    logic [31:0]  r_root;

    logic [32:0]  rem2;
    logic         ge;
    logic [63:0]  trial;
    logic [63:0]  n_x;
    logic [63:0]  n_res;

    always_comb begin
        rem2  = {r_rem, (r_cnt == 7'd72)};
        ge    = rem2 >= {1'b0, r_mag};
        trial = r_res + r_bit;
        if (r_x >= trial) begin
            n_x   = r_x - trial;
            n_res = (r_res >> 1) + r_bit;
        end else begin
            n_x   = r_x;
            n_res = r_res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RSQ_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                RSQ_IDLE: begin
                    if (i_req.start) begin
                        r_mag   <= i_req.mag;
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_cnt   <= 7'd72;
                        r_state <= RSQ_DIV;
                    end
                end
                RSQ_DIV: begin
                    r_rem <= ge ? 32'(rem2 - {1'b0, r_mag}) : rem2[31:0];
                    r_quo <= {r_quo[61:0], ge};
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == 7'd0) begin
                        r_x     <= {r_quo, ge};
                        r_res   <= '0;
                        r_bit   <= 64'd1 << 62;
                        r_state <= RSQ_SQRT;
                    end
                end
                RSQ_SQRT: begin
                    r_x   <= n_x;
                    r_res <= n_res;
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_root  <= n_res[31:0];
                        r_done  <= 1'b1;
                        r_state <= RSQ_IDLE;
                    end
                end
                default: r_state <= RSQ_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_root;

endmodule

/* rtl/core/sparse_triple_product_diagonal_top.sv */
// diagonal scaling block: csr stores, merge sequencer and output register
// compute: setup, then per factor entry a merge of the a row with the factor row, with an
// extra accumulate step on a column match; zero-valued factor entries are skipped, and the
// reciprocal square root runs when |sum| > 1024; out-of-range rows skip the store lookups
// throughput: one request at a time, input held off until the result register is loaded
// reset clears control and sets row_count to 1, store contents are kept
`timescale 1ns / 1ps
module sparse_triple_product_diagonal_top #(
    parameter int MAX_ROWS           = stpd_pkg::MAX_ROWS_DEF,
    parameter int MAX_A_ENTRIES      = stpd_pkg::MAX_A_DEF,
    parameter int MAX_FACTOR_ENTRIES = stpd_pkg::MAX_FACTOR_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [10:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // addr, pointer_value, column, coef_first, coef_second
    input  logic [103:0] s_axis_tdata,
    // func
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // row, scale, status, zero fill
    output logic [47:0]  m_axis_tdata
);
    import stpd_pkg::*;

    localparam int RW = $clog2(MAX_ROWS + 1);
    localparam int AW = $clog2(MAX_A_ENTRIES);
    localparam int FW = $clog2(MAX_FACTOR_ENTRIES);
    localparam int AWD = COL_W + VAL_W;
    localparam int FWD = COL_W + 2 * VAL_W;

    logic [PTR_W-1:0]        in_addr;
    logic [PTR_W-1:0]        in_ptr;
    logic [COL_W-1:0]        in_col;
    logic signed [VAL_W-1:0] in_c1;
    logic signed [VAL_W-1:0] in_c2;
    logic                    acc_in;

    assign in_addr = s_axis_tdata[14:0];
    assign in_ptr  = s_axis_tdata[29:15];
    assign in_col  = s_axis_tdata[39:30];
    assign in_c1   = s_axis_tdata[71:40];
    assign in_c2   = s_axis_tdata[103:72];

    t_state r_state, n_state;
    logic [CNT_W-1:0]        r_row_count;
    logic [PTR_W-1:0]        r_addr;
    logic [PTR_W-1:0]        r_fs, r_fe, r_j, r_ka, r_ae, r_kf;
    logic [COL_W-1:0]        r_fc;
    logic signed [VAL_W-1:0] r_lv, r_inner, r_sum;
    logic signed [63:0]      r_prod;
    logic signed [VAL_W-1:0] r_scale;
    t_status                 r_status;
    logic                    r_ovalid;
    logic [ROW_W-1:0]        r_orow;
    logic signed [VAL_W-1:0] r_oscale;
    t_status                 r_ostatus;

    // store ports
    logic [RW-1:0]    ars_raddr, frs_raddr;
    logic [PTR_W-1:0] ars_q, frs_q;
    logic [AW-1:0]    ae_raddr;
    logic [AWD-1:0]   ae_q;
    logic [FW-1:0]    fe_raddr;
    logic [FWD-1:0]   fe_q;
    logic             we_ars, we_frs, we_ae, we_fe;

    assign acc_in = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    assign we_ars = acc_in && (t_func'(s_axis_tuser) == F_A_PTR)
                    && ({17'b0, in_addr} <= 32'(MAX_ROWS));
    assign we_frs = acc_in && (t_func'(s_axis_tuser) == F_F_PTR)
                    && ({17'b0, in_addr} <= 32'(MAX_ROWS));
    assign we_ae  = acc_in && (t_func'(s_axis_tuser) == F_A_ENTRY)
                    && ({17'b0, in_addr} < 32'(MAX_A_ENTRIES));
    assign we_fe  = acc_in && (t_func'(s_axis_tuser) == F_F_ENTRY)
                    && ({17'b0, in_addr} < 32'(MAX_FACTOR_ENTRIES));

    stpd_ram #(.WIDTH(PTR_W), .DEPTH(MAX_ROWS + 1)) u_a_row_start (
        .i_clk(i_clk), .i_we(we_ars), .i_waddr(RW'(in_addr)), .i_wdata(in_ptr),
        .i_raddr(ars_raddr), .o_rdata(ars_q)
    );
    stpd_ram #(.WIDTH(PTR_W), .DEPTH(MAX_ROWS + 1)) u_factor_row_start (
        .i_clk(i_clk), .i_we(we_frs), .i_waddr(RW'(in_addr)), .i_wdata(in_ptr),
        .i_raddr(frs_raddr), .o_rdata(frs_q)
    );
    stpd_ram #(.WIDTH(AWD), .DEPTH(MAX_A_ENTRIES)) u_a_entry (
        .i_clk(i_clk), .i_we(we_ae), .i_waddr(AW'(in_addr)), .i_wdata({in_c1, in_col}),
        .i_raddr(ae_raddr), .o_rdata(ae_q)
    );
    stpd_ram #(.WIDTH(FWD), .DEPTH(MAX_FACTOR_ENTRIES)) u_factor_entry (
        .i_clk(i_clk), .i_we(we_fe), .i_waddr(FW'(in_addr)),
        .i_wdata({in_c2, in_c1, in_col}),
        .i_raddr(fe_raddr), .o_rdata(fe_q)
    );

    logic [COL_W-1:0]        f_col, a_col;
    logic signed [VAL_W-1:0] f_lv, f_uv, a_val;
    logic [PTR_W-1:0]        last;
    logic                    has_last;
    logic signed [VAL_W-1:0] lv_eff, uv_eff;
    logic                    out_range, out_free;
    logic [31:0]             mag;
    t_rsq_req                rsq_req;
    t_rsq_rsp                rsq_rsp;

    assign f_col    = fe_q[COL_W-1:0];
    assign f_lv     = fe_q[COL_W+VAL_W-1:COL_W];
    assign f_uv     = fe_q[FWD-1:COL_W+VAL_W];
    assign a_col    = ae_q[COL_W-1:0];
    assign a_val    = ae_q[AWD-1:COL_W];
    assign has_last = r_fs < r_fe;
    assign last     = r_fe - PTR_W'(1);
    assign lv_eff   = (has_last && r_j == last) ? Q_ONE : f_lv;
    assign uv_eff   = (has_last && r_kf == last) ? Q_ONE : f_uv;
    assign out_range = ({17'b0, in_addr} >= {21'b0, r_row_count})
                       || ({17'b0, in_addr} >= 32'(MAX_ROWS));
    assign out_free = !r_ovalid || m_axis_tready;
    assign mag      = r_sum[VAL_W-1] ? 32'(-{r_sum[VAL_W-1], r_sum}) : 32'(r_sum);

    assign rsq_req.start = (r_state == S_FIN) && (r_sum != '0) && (mag > RSQ_SAT_LIMIT);
    assign rsq_req.mag   = mag;

    stpd_rsqrt u_rsqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(rsq_req), .o_rsp(rsq_rsp)
    );

    always_comb begin
        ars_raddr = RW'(r_fc) + RW'(1);
        frs_raddr = RW'(r_addr) + RW'(1);
        ae_raddr  = AW'(r_ka);
        fe_raddr  = FW'(r_kf);
        case (r_state)
            S_FSR:  frs_raddr = RW'(r_addr);
            S_JCHK: fe_raddr  = FW'(r_j);
            S_JRD:  ars_raddr = RW'(f_col);
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc_in && t_func'(s_axis_tuser) == F_COMPUTE) begin
                    n_state = out_range ? S_OUT : S_FSR;
                end
            end
            S_FSR:  n_state = S_FS;
            S_FS:   n_state = S_FE;
            S_FE:   n_state = S_JCHK;
            S_JCHK: n_state = (r_j < r_fe) ? S_JRD : S_FIN;
            S_JRD: begin
                if (lv_eff == '0 || {22'b0, f_col} >= 32'(MAX_ROWS)) begin
                    n_state = S_JCHK;
                end else begin
                    n_state = S_AS;
                end
            end
            S_AS:   n_state = S_AE;
            S_AE:   n_state = S_MCHK;
            S_MCHK: n_state = (r_ka < r_ae && r_kf < r_fe) ? S_MCMP : S_OMUL;
            S_MCMP: n_state = (a_col == f_col) ? S_MACC : S_MCHK;
            S_MACC: n_state = S_MCHK;
            S_OMUL: n_state = S_OACC;
            S_OACC: n_state = S_JCHK;
            S_FIN:  n_state = rsq_req.start ? S_RSQ : S_OUT;
            S_RSQ:  n_state = rsq_rsp.done ? S_OUT : S_RSQ;
            S_OUT:  n_state = out_free ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_count <= CNT_W'(1);
            r_ovalid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_row_count <= i_cfg_wdata;
            end
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == S_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_addr   <= in_addr;
                r_status <= ST_RANGE;
                r_scale  <= '0;
            end
            S_FS: r_fs <= frs_q;
            S_FE: begin
                r_fe  <= ({17'b0, frs_q} > 32'(MAX_FACTOR_ENTRIES))
                         ? PTR_W'(MAX_FACTOR_ENTRIES) : frs_q;
                r_j   <= r_fs;
                r_sum <= '0;
            end
            S_JRD: begin
                r_lv <= lv_eff;
                r_fc <= f_col;
                if (n_state == S_JCHK) begin
                    r_j <= r_j + PTR_W'(1);
                end
            end
            S_AS: r_ka <= ars_q;
            S_AE: begin
                r_ae    <= ({17'b0, ars_q} > 32'(MAX_A_ENTRIES))
                           ? PTR_W'(MAX_A_ENTRIES) : ars_q;
                r_kf    <= r_fs;
                r_inner <= '0;
            end
            S_MCMP: begin
                r_prod <= 64'(a_val) * 64'(uv_eff);
                if (a_col == f_col) begin
                    r_ka <= r_ka + PTR_W'(1);
                    r_kf <= r_kf + PTR_W'(1);
                end else if (a_col < f_col) begin
                    r_ka <= r_ka + PTR_W'(1);
                end else begin
                    r_kf <= r_kf + PTR_W'(1);
                end
            end
            S_MACC: r_inner <= sat_add(r_inner, q_round(r_prod));
            S_OMUL: r_prod  <= 64'(r_lv) * 64'(r_inner);
            S_OACC: begin
                r_sum <= sat_add(r_sum, q_round(r_prod));
                r_j   <= r_j + PTR_W'(1);
            end
            S_FIN: begin
                if (r_sum == '0) begin
                    r_status <= ST_ZERO;
                    r_scale  <= '0;
                end else begin
                    r_status <= ST_OK;
                    r_scale  <= r_sum[VAL_W-1] ? -S32_MAX : S32_MAX;
                end
            end
            S_RSQ: begin
                if (rsq_rsp.done) begin
                    r_scale <= r_sum[VAL_W-1] ? -$signed(rsq_rsp.root)
                                              : $signed(rsq_rsp.root);
                end
            end
            S_OUT: begin
                if (out_free) begin
                    r_orow    <= r_addr[ROW_W-1:0];
                    r_oscale  <= r_scale;
                    r_ostatus <= r_status;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'b0, r_ostatus, r_oscale, r_orow};

endmodule

/* tb/sparse_triple_product_diagonal_checker.sv */
// checker: tracks loads, predicts each diagonal scale result and compares it
`timescale 1ns / 1ps
module sparse_triple_product_diagonal_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [10:0]  i_cfg_wdata,
    input  logic         i_req_valid,
    input  logic         i_req_ready,
    // addr, pointer_value, column, coef_first, coef_second
    input  logic [103:0] i_req_data,
    // func
    input  logic [2:0]   i_req_user,
    input  logic         i_rsp_valid,
    input  logic         i_rsp_ready,
    // row, scale, status, zero fill
    input  logic [47:0]  i_rsp_data,
    output int           o_pending,
    output int           o_errors
);
    import stpd_pkg::*;

    localparam int NROWS = MAX_ROWS_DEF;
    localparam int NA    = MAX_A_DEF;
    localparam int NF    = MAX_FACTOR_DEF;

    // status in the top bits, row in the lowest, as on the result bus
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  scale;
        logic [ROW_W-1:0]  row;
    } t_scale_result;

    logic [10:0]             rows_in_use;
    logic [PTR_W-1:0]        a_start [0:NROWS];
    logic [COL_W-1:0]        a_col   [0:NA-1];
    logic signed [VAL_W-1:0] a_val   [0:NA-1];
    logic [PTR_W-1:0]        f_start [0:NROWS];
    logic [COL_W-1:0]        f_col   [0:NF-1];
    logic signed [VAL_W-1:0] fl_val  [0:NF-1];
    logic signed [VAL_W-1:0] fu_val  [0:NF-1];
    t_scale_result           scale_q [$];
    int                      mismatches;

    function automatic logic signed [31:0] clip32(input longint x);
        if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (x < -64'sd2147483648) return 32'sh8000_0000;
        return x[31:0];
    endfunction

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        return clip32(longint'(a) + longint'(b));
    endfunction

    function automatic logic signed [31:0] mul_q824(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b) + 64'sd8388608;
        return clip32(p >>> 24);
    endfunction

    function automatic longint unsigned root64(input longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned inv_root(input longint unsigned m);
        longint unsigned q1, r1, t;
        if (m <= 1024) return 64'd2147483647;
        q1 = (64'd1 << 40) / m;
        r1 = (64'd1 << 40) % m;
        t = (q1 << 32) + ((r1 << 32) / m);
        return root64(t);
    endfunction

    function automatic t_scale_result diag_scale(input logic [14:0] addr);
        t_scale_result           r;
        longint                  fs, fe, last, j, as_, ae, ka, kf;
        logic signed [31:0]      sum, inner, lv, uv;
        logic [9:0]              fc;
        longint unsigned         m, q;
        r.row = addr[9:0];
        r.scale = '0;
        if (addr >= rows_in_use || addr >= NROWS) begin
            r.status = ST_RANGE;
            return r;
        end
        fs = f_start[addr];
        fe = f_start[addr + 1];
        if (fe > NF) fe = NF;
        last = (fs < fe) ? fe - 1 : 0;
        sum = 0;
        for (j = fs; j < fe; j++) begin
            lv = (j == last) ? Q_ONE : fl_val[j];
            fc = f_col[j];
            if (lv == 0) continue;
            inner = 0;
            as_ = a_start[fc];
            ae = a_start[fc + 1];
            if (ae > NA) ae = NA;
            ka = as_;
            kf = fs;
            while (ka < ae && kf < fe) begin
                if (a_col[ka] == f_col[kf]) begin
                    uv = (kf == last) ? Q_ONE : fu_val[kf];
                    inner = add_sat(inner, mul_q824(a_val[ka], uv));
                    ka++;
                    kf++;
                end else if (a_col[ka] < f_col[kf]) begin
                    ka++;
                end else begin
                    kf++;
                end
            end
            sum = add_sat(sum, mul_q824(lv, inner));
        end
        if (sum == 0) begin
            r.status = ST_ZERO;
        end else begin
            m = (sum < 0) ? longint'(-longint'(sum)) : longint'(sum);
            q = inv_root(m);
            r.scale = (sum < 0) ? -q[31:0] : q[31:0];
            r.status = ST_OK;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        logic [14:0]   addr;
        logic [14:0]   ptr;
        t_scale_result got, want;
        if (!i_rst_n) begin
            rows_in_use = 11'd1;
            scale_q.delete();
            mismatches = 0;
            o_pending = 0;
        end else begin
            if (i_cfg_we) rows_in_use = i_cfg_wdata;
            if (i_req_valid && i_req_ready) begin
                addr = i_req_data[14:0];
                ptr = i_req_data[29:15];
                case (i_req_user)
                    F_A_PTR: if (addr <= NROWS) a_start[addr] = ptr;
                    F_A_ENTRY: if (addr < NA) begin
                        a_col[addr] = i_req_data[39:30];
                        a_val[addr] = i_req_data[71:40];
                    end
                    F_F_PTR: if (addr <= NROWS) f_start[addr] = ptr;
                    F_F_ENTRY: if (addr < NF) begin
                        f_col[addr] = i_req_data[39:30];
                        fl_val[addr] = i_req_data[71:40];
                        fu_val[addr] = i_req_data[103:72];
                    end
                    F_COMPUTE: scale_q.push_back(diag_scale(addr));
                    default: ;
                endcase
            end
            if (i_rsp_valid && i_rsp_ready) begin
                got = i_rsp_data[43:0];
                if (scale_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result row %0d scale %h status %0d",
                                 got.row, got.scale, got.status);
                end else begin
                    want = scale_q.pop_front();
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp row %0d scale %h status %0d, ",
                                      "got row %0d scale %h status %0d"},
                                     want.row, want.scale, want.status,
                                     got.row, got.scale, got.status);
                    end
                end
            end
            o_pending = scale_q.size();
        end
    end

    assign o_errors = mismatches;

endmodule

/* tb/tb_sparse_triple_product_diagonal_top.sv */
// testbench top: builds small csr problems, drives requests and gives the verdict
`timescale 1ns / 1ps
module tb_sparse_triple_product_diagonal_top;
    import stpd_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [10:0]  i_cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata;
    logic [2:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [47:0]  m_axis_tdata;
    int           pending;
    int           errors;
    int           sent;
    int           idle_cycles;
    bit           quiet;
    bit           hold_off;

    sparse_triple_product_diagonal_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    sparse_triple_product_diagonal_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req_valid(s_axis_tvalid),
        .i_req_ready(s_axis_tready),
        .i_req_data (s_axis_tdata),
        .i_req_user (s_axis_tuser),
        .i_rsp_valid(m_axis_tvalid),
        .i_rsp_ready(m_axis_tready),
        .i_rsp_data (m_axis_tdata),
        .o_pending  (pending),
        .o_errors   (errors)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side backpressure
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send(input logic [2:0] func, input logic [14:0] addr,
                        input logic [14:0] ptr, input logic [9:0] col,
                        input logic [31:0] c1, input logic [31:0] c2);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= func;
        s_axis_tdata <= {c2, c1, col, ptr, addr};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent++;
    endtask

    task automatic set_rows(input logic [10:0] rc);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= rc;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] coef_pick();
        case ($urandom_range(0, 15))
            0: return 32'h0;
            1, 2: return $urandom;
            default: return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
        endcase
    endfunction

    // noise that the block ignores
    task automatic send_noise();
        case ($urandom_range(0, 2))
            0: send(3'($urandom_range(5, 7)), 15'($urandom), 15'($urandom), 10'($urandom),
                    $urandom, $urandom);
            1: send(($urandom_range(0, 1) != 0) ? F_A_PTR : F_F_PTR,
                    15'($urandom_range(1025, 32767)), 15'($urandom), 10'($urandom),
                    $urandom, $urandom);
            default: send(($urandom_range(0, 1) != 0) ? F_A_ENTRY : F_F_ENTRY,
                          15'($urandom_range(16384, 32767)), 15'($urandom),
                          10'($urandom), $urandom, $urandom);
        endcase
    endtask

    // loads a random csr problem with n rows; factor columns stay below n
    task automatic load_problem(input int n, input bit at_end, input bit overlap);
        int fnnz[8];
        int annz[8];
        int fcnt, acnt, fbase, abase, p, slot, c;
        fcnt = 0;
        acnt = 0;
        for (int r = 0; r < n; r++) begin
            fnnz[r] = $urandom_range(0, 4);
            annz[r] = $urandom_range(0, 6);
            fcnt += fnnz[r];
            acnt += annz[r];
        end
        fbase = at_end ? 16384 - fcnt : $urandom_range(0, 8000);
        abase = at_end ? 16384 - acnt : $urandom_range(0, 8000);
        p = fbase;
        for (int r = 0; r < n; r++) begin
            send(F_F_PTR, 15'(r), 15'(p), 10'($urandom), $urandom, $urandom);
            p += fnnz[r];
        end
        send(F_F_PTR, 15'(n), 15'(at_end ? p + $urandom_range(0, 16383) : p),
             10'($urandom), $urandom, $urandom);
        p = abase;
        for (int r = 0; r < n; r++) begin
            send(F_A_PTR, 15'(r), 15'(p), 10'($urandom), $urandom, $urandom);
            p += annz[r];
        end
        send(F_A_PTR, 15'(n), 15'(at_end ? p + $urandom_range(0, 16383) : p),
             10'($urandom), $urandom, $urandom);
        slot = fbase;
        for (int r = 0; r < n; r++) begin
            c = 0;
            for (int k = 0; k < fnnz[r]; k++) begin
                c += $urandom_range(0, 2);
                send(F_F_ENTRY, 15'(slot), 15'($urandom), 10'((c < n) ? c : n - 1),
                     coef_pick(), coef_pick());
                slot++;
            end
        end
        slot = abase;
        for (int r = 0; r < n; r++) begin
            c = 0;
            for (int k = 0; k < annz[r]; k++) begin
                c += $urandom_range(0, 2);
                send(F_A_ENTRY, 15'(slot), 15'($urandom), 10'(c), coef_pick(), $urandom);
                slot++;
            end
        end
        if (overlap && n > 1)
            send(F_F_PTR, 15'($urandom_range(1, n - 1)), 15'(fbase + $urandom_range(0, fcnt)),
                 10'($urandom), $urandom, $urandom);
    endtask

    initial begin
        int n, ph;
        logic [10:0] rc;
        int lim;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        sent = 0;
        quiet = 1'b0;
        hold_off = 1'b0;
        idle_cycles = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // two-row problem with extreme values, empty row 0
        send(F_F_PTR, 15'd0, 15'd0, 10'd0, 32'h0, 32'h0);
        send(F_F_PTR, 15'd1, 15'd0, 10'd0, 32'h0, 32'h0);
        send(F_F_PTR, 15'd2, 15'd2, 10'd0, 32'h0, 32'h0);
        send(F_F_ENTRY, 15'd0, 15'd0, 10'd0, 32'h8000_0000, 32'h7FFF_FFFF);
        send(F_F_ENTRY, 15'd1, 15'd0, 10'd1, 32'h7FFF_FFFF, 32'h8000_0000);
        send(F_A_PTR, 15'd0, 15'd0, 10'd0, 32'h0, 32'h0);
        send(F_A_PTR, 15'd1, 15'd2, 10'd0, 32'h0, 32'h0);
        send(F_A_PTR, 15'd2, 15'd3, 10'd0, 32'h0, 32'h0);
        send(F_A_ENTRY, 15'd0, 15'd0, 10'd0, 32'h7FFF_FFFF, 32'h0);
        send(F_A_ENTRY, 15'd1, 15'd0, 10'd1, 32'h8000_0000, 32'h0);
        send(F_A_ENTRY, 15'd2, 15'd0, 10'd1, 32'h0000_0005, 32'h0);
        send(3'd5, 15'h7FFF, 15'h7FFF, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(3'd7, 15'h0, 15'h0, 10'h0, 32'h0, 32'h0);
        send(F_A_PTR, 15'd1025, 15'h7FFF, 10'h3FF, 32'h0, 32'h0);
        send(F_F_ENTRY, 15'h7FFF, 15'h0, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(F_COMPUTE, 15'd0, 15'd0, 10'd0, 32'h0, 32'h0);
        send(F_COMPUTE, 15'd1, 15'd0, 10'd0, 32'h0, 32'h0);
        send(F_COMPUTE, 15'h7FFF, 15'd0, 10'd0, 32'h0, 32'h0);
        set_rows(11'd1024);
        send(F_COMPUTE, 15'd1, 15'd0, 10'd0, 32'h0, 32'h0);
        send(F_COMPUTE, 15'd1024, 15'd0, 10'd0, 32'h0, 32'h0);

        ph = 0;
        while (sent < 1450) begin
            n = $urandom_range(1, 8);
            case ($urandom_range(0, 5))
                0: rc = 11'd1;
                1: rc = 11'd1024;
                2: rc = 11'($urandom_range(1025, 2047));
                default: rc = 11'($urandom_range(1, 12));
            endcase
            if (sent > 1250) quiet = 1'b1;
            set_rows(rc);
            load_problem(n, (ph % 5) == 3, (ph % 4) == 1);
            lim = (n < rc) ? n : rc;
            if (ph == 1) hold_off = 1'b1;
            for (int k = 0; k < 25; k++) begin
                if ($urandom_range(0, 5) == 0)
                    send_noise();
                else if ($urandom_range(0, 4) == 0 || lim == 0)
                    send(F_COMPUTE, 15'($urandom_range((rc < 1024) ? rc : 1024, 32767)),
                         15'($urandom), 10'($urandom), $urandom, $urandom);
                else
                    send(F_COMPUTE, 15'($urandom_range(0, lim - 1)), 15'($urandom),
                         10'($urandom), $urandom, $urandom);
            end
            ph++;
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
